// File: src/brfb_pkg.sv
`timescale 1ns / 1ps

package brfb_pkg;

	// Defaults handed to the top level
	localparam int RING_SLOTS_DEF = 256;
	localparam int QUEUE_DEPTH    = 2;

	// Field widths
	localparam int KIND_W = 2;
	localparam int BYTE_W = 8;
	localparam int CFG_W  = 7;
	localparam int FREE_W = 8;

	// Burst limit range
	localparam logic [CFG_W-1:0] BURST_MIN = CFG_W'(1);
	localparam logic [CFG_W-1:0] BURST_MAX = CFG_W'(64);

	// Input item kinds
	localparam logic [KIND_W-1:0] KIND_ENQ    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BURST  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd2;

	// Commands passed from the front to the back
	localparam logic [1:0] OP_NOP   = 2'd0;
	localparam logic [1:0] OP_ENQ   = 2'd1;
	localparam logic [1:0] OP_BURST = 2'd2;
	localparam logic [1:0] OP_SEND  = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [BYTE_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		logic              accepted;
		logic [FREE_W-1:0] free_space;
		logic              empty_res;
		logic              last;
	} res_t;

endpackage

// File: src/byte_ring_fifo_burst_drain.sv
`timescale 1ns / 1ps

// Byte ring buffer that feeds a serial transmitter.
// Input channel: push/full with kind, data_byte, tx_ready. Kind 0 enqueues
// data_byte, kind 1 drains up to burst_size bytes clamped to 1..64, kind 2
// drains one byte when tx_ready is set. Results leave through empty/pop;
// each carries tx_valid, tx_byte, accepted, free_space, empty_res and last.
// Configuration: cfg_valid/cfg_ready/cfg_data writes burst_size (ready is
// always high); write it only while the block is idle.
// The result of an enqueue or of a send that moves nothing passes through
// the input register, the command queue and the result queue; a send with
// bytes to drain first moves the back end into its drain state. Enqueues and
// empty sends run at one item per cycle while the receiver keeps popping.
// Between drained bytes the back end passes through a gap state that waits
// for the registered read port of the ring memory; it takes no command meanwhile.
// Reset clears both ring indices and the queues and sets burst_size to 1.
// When the receiver stalls pop, the result queue fills, the back end stops,
// the command queue fills and full rises; nothing is lost.
module byte_ring_fifo_burst_drain import brfb_pkg::*; #(
	parameter int RING_SLOTS = RING_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [KIND_W-1:0] kind,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              tx_ready,
	output logic              empty,
	input  logic              pop,
	output logic              tx_valid,
	output logic [BYTE_W-1:0] tx_byte,
	output logic              accepted,
	output logic [FREE_W-1:0] free_space,
	output logic              empty_res,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);

	cmd_t fr_cmd;
	logic fr_push;
	logic cq_full;
	cmd_t cq_cmd;
	logic cq_empty;
	logic cq_pop;
	res_t bk_res;
	logic bk_push;
	logic rq_full;
	res_t rq_res;

	assign cfg_ready = 1'b1;

	brfb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.data_byte (data_byte),
		.tx_ready  (tx_ready),
		.cmd       (fr_cmd),
		.cmd_push  (fr_push),
		.cmd_full  (cq_full)
	);

	brfb_queue #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fr_push),
		.wr_data (fr_cmd),
		.q_full  (cq_full),
		.rd_en   (cq_pop),
		.rd_data (cq_cmd),
		.q_empty (cq_empty)
	);

	brfb_back #(
		.RING_SLOTS (RING_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cq_cmd),
		.cmd_empty (cq_empty),
		.cmd_pop   (cq_pop),
		.res       (bk_res),
		.res_push  (bk_push),
		.res_full  (rq_full)
	);

	brfb_queue #(
		.WIDTH ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (bk_push),
		.wr_data (bk_res),
		.q_full  (rq_full),
		.rd_en   (pop),
		.rd_data (rq_res),
		.q_empty (empty)
	);

	// Drive result fields from the queue head
	assign tx_valid   = rq_res.tx_valid;
	assign tx_byte    = rq_res.tx_byte;
	assign accepted   = rq_res.accepted;
	assign free_space = rq_res.free_space;
	assign empty_res  = rq_res.empty_res;
	assign last       = rq_res.last;

endmodule

// File: src/brfb_queue.sv
`timescale 1ns / 1ps

module brfb_queue import brfb_pkg::*; #(
	parameter int WIDTH = 10,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             q_full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             q_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [WIDTH-1:0] ent_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (cnt_q == CW'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = ent_q[rd_ptr_q];

	// Store the incoming item
	always_ff @(posedge clk) begin
		if (do_wr)
			ent_q[wr_ptr_q] <= wr_data;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// File: src/brfb_front.sv
`timescale 1ns / 1ps

module brfb_front import brfb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [KIND_W-1:0] kind,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              tx_ready,
	output cmd_t              cmd,
	output logic              cmd_push,
	input  logic              cmd_full
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;
	logic adv;

	// Hold the stage while the command queue is full
	assign adv      = !valid_s1 || !cmd_full;
	assign full     = !adv;
	assign cmd      = cmd_s1;
	assign cmd_push = valid_s1;

	// Classify the item into a command
	always_comb begin
		cmd_d.data = data_byte;
		case (kind)
			KIND_ENQ:    cmd_d.op = OP_ENQ;
			KIND_BURST:  cmd_d.op = OP_BURST;
			KIND_SINGLE: cmd_d.op = tx_ready ? OP_SEND : OP_NOP;
			default:     cmd_d.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= push;
	end

	always_ff @(posedge clk) begin
		if (adv && push)
			cmd_s1 <= cmd_d;
	end

endmodule

// File: src/brfb_back.sv
`timescale 1ns / 1ps

module brfb_back import brfb_pkg::*; #(
	parameter int RING_SLOTS = RING_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  cmd_t             cmd,
	input  logic             cmd_empty,
	output logic             cmd_pop,
	output res_t             res,
	output logic             res_push,
	input  logic             res_full
);

	localparam int IDX_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int SW    = (IDX_W > FREE_W) ? IDX_W : FREE_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_SLOTS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_GAP   = 2'd2;

	logic [BYTE_W-1:0] ring_q [RING_SLOTS];
	logic [BYTE_W-1:0] rdata_q;
	logic [IDX_W-1:0]  wr_idx_q, wr_idx_d;
	logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
	logic [IDX_W-1:0]  cnt_q, cnt_d;
	logic [CFG_W-1:0]  burst_q;
	logic [CFG_W-1:0]  remain_q, remain_d;
	logic [CFG_W-1:0]  limit;
	logic [1:0]        state_q, state_d;
	logic              mem_we;
	logic              fin;
	logic [SW-1:0]     free_w;

	// Clamp the burst limit into its range
	always_comb begin
		if (burst_q < BURST_MIN)
			limit = BURST_MIN;
		else if (burst_q > BURST_MAX)
			limit = BURST_MAX;
		else
			limit = burst_q;
	end

	assign fin    = (cnt_q == IDX_W'(1)) || (remain_q == CFG_W'(1));
	assign free_w = SW'(RING_SLOTS - 1) - SW'(cnt_d);

	// Sequence commands and build results
	always_comb begin
		state_d  = state_q;
		wr_idx_d = wr_idx_q;
		rd_idx_d = rd_idx_q;
		cnt_d    = cnt_q;
		remain_d = remain_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		mem_we   = 1'b0;
		res      = '0;
		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_ENQ: begin
							res_push = 1'b1;
							res.last = 1'b1;
							if (cnt_q != LAST_IDX) begin
								mem_we       = 1'b1;
								wr_idx_d     = (wr_idx_q == LAST_IDX) ? '0
								               : wr_idx_q + IDX_W'(1);
								cnt_d        = cnt_q + IDX_W'(1);
								res.accepted = 1'b1;
							end
						end
						OP_BURST: begin
							if (cnt_q != '0) begin
								remain_d = limit;
								state_d  = ST_DRAIN;
							end else begin
								res_push = 1'b1;
								res.last = 1'b1;
							end
						end
						OP_SEND: begin
							if (cnt_q != '0) begin
								remain_d = CFG_W'(1);
								state_d  = ST_DRAIN;
							end else begin
								res_push = 1'b1;
								res.last = 1'b1;
							end
						end
						default: begin
							res_push = 1'b1;
							res.last = 1'b1;
						end
					endcase
				end
			end
			ST_DRAIN: begin
				if (!res_full) begin
					res_push     = 1'b1;
					res.tx_valid = 1'b1;
					res.tx_byte  = rdata_q;
					res.last     = fin;
					rd_idx_d     = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + IDX_W'(1);
					cnt_d        = cnt_q - IDX_W'(1);
					remain_d     = remain_q - CFG_W'(1);
					state_d      = fin ? ST_IDLE : ST_GAP;
				end
			end
			ST_GAP: begin
				// wait for the head byte at the new read index
				state_d = ST_DRAIN;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res.free_space = (free_w > SW'(255)) ? FREE_W'(255) : free_w[FREE_W-1:0];
		res.empty_res  = (cnt_d == '0);
	end

	// Ring storage with registered head read
	always_ff @(posedge clk) begin
		if (mem_we)
			ring_q[wr_idx_q] <= cmd.data;
		rdata_q <= ring_q[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			cnt_q    <= '0;
			remain_q <= '0;
			burst_q  <= BURST_MIN;
		end else begin
			state_q  <= state_d;
			wr_idx_q <= wr_idx_d;
			rd_idx_q <= rd_idx_d;
			cnt_q    <= cnt_d;
			remain_q <= remain_d;
			if (cfg_we)
				burst_q <= cfg_data;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LAST_IDX)
		else $error("byte count above ring capacity");

	a_gap_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GAP |=> state_q == ST_DRAIN)
		else $error("gap state not followed by drain");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> (cnt_q != '0 && remain_q != '0))
		else $error("drain with no byte or no burst budget");

	a_pop_with_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (!cmd_empty && state_q == ST_IDLE))
		else $error("command taken outside idle or from empty queue");
`endif

endmodule

// File: tb/byte_ring_fifo_burst_drain_tb.sv
`timescale 1ns / 1ps

module byte_ring_fifo_burst_drain_tb;
	import brfb_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int RING_BYTES   = RING_SLOTS_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES  = 80;
	localparam int FILL_ITEMS   = 70;
	localparam int RANDOM_ITEMS = 12;
	localparam int CYCLE_LIMIT  = 200_000;
	localparam int MAX_REPORTS  = 40;

	// Track ring contents and the results each item must produce
	class ring_scoreboard;
		logic [BYTE_W-1:0] slots [RING_BYTES];
		int head;
		int tail;
		logic [CFG_W-1:0] burst_cfg;
		res_t due[$];
		int errors;
		int items;
		int results;
		int bytes_sent;
		int dropped;

		function new();
			head = 0;
			tail = 0;
			// burst_size comes out of reset at one
			burst_cfg = CFG_W'(1);
			errors = 0;
			items = 0;
			results = 0;
			bytes_sent = 0;
			dropped = 0;
		endfunction

		function void set_burst(logic [CFG_W-1:0] value);
			burst_cfg = value;
		endfunction

		// Append one result, carrying the space and emptiness that now hold
		function void queue_result(logic valid, logic [BYTE_W-1:0] b, logic acc,
			logic fin);
			res_t r;
			int space;
			space = (RING_BYTES - 1) - ((tail + RING_BYTES - head) % RING_BYTES);
			if (space > 255) begin
				space = 255;
			end
			r.tx_valid   = valid;
			r.tx_byte    = b;
			r.accepted   = acc;
			r.free_space = FREE_W'(space);
			r.empty_res  = (tail == head);
			r.last       = fin;
			due.push_back(r);
		endfunction

		function void note_item(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] d, logic rdy);
			int limit;
			int n;
			logic [BYTE_W-1:0] b;
			items++;
			if (k == KIND_ENQ) begin
				// Store unless the one spare slot would be used
				if ((tail + 1) % RING_BYTES != head) begin
					slots[tail] = d;
					tail = (tail + 1) % RING_BYTES;
					queue_result(1'b0, '0, 1'b1, 1'b1);
				end else begin
					dropped++;
					queue_result(1'b0, '0, 1'b0, 1'b1);
				end
			end else if (k == KIND_BURST && tail != head) begin
				// Clamp the burst limit into its legal range
				limit = burst_cfg;
				if (limit < BURST_MIN) begin
					limit = BURST_MIN;
				end
				if (limit > BURST_MAX) begin
					limit = BURST_MAX;
				end
				n = 0;
				while (tail != head && n < limit) begin
					b = slots[head];
					head = (head + 1) % RING_BYTES;
					n++;
					queue_result(1'b1, b, 1'b0, (tail == head) || (n >= limit));
				end
			end else if (k == KIND_SINGLE && rdy && tail != head) begin
				b = slots[head];
				head = (head + 1) % RING_BYTES;
				queue_result(1'b1, b, 1'b0, 1'b1);
			end else begin
				// Empty send, transmitter busy or unused kind: nothing moves
				queue_result(1'b0, '0, 1'b0, 1'b1);
			end
		endfunction

		function bit same(string name, logic [7:0] want, logic [7:0] seen);
			if (want !== seen) begin
				if (errors < MAX_REPORTS) begin
					$display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
				end
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_result(res_t got);
			res_t want;
			bit ok;
			if (due.size() == 0) begin
				if (errors < MAX_REPORTS) begin
					$display("%0t: result with no item waiting, expected none,",
						$time);
					$display("    got tx_valid %b tx_byte %0d",
						got.tx_valid, got.tx_byte);
				end
				errors++;
				return;
			end
			want = due.pop_front();
			results++;
			if (want.tx_valid) begin
				bytes_sent++;
			end
			ok = 1'b1;
			ok &= same("tx_valid", want.tx_valid, got.tx_valid);
			ok &= same("tx_byte", want.tx_byte, got.tx_byte);
			ok &= same("accepted", want.accepted, got.accepted);
			ok &= same("free_space", want.free_space, got.free_space);
			ok &= same("empty_res", want.empty_res, got.empty_res);
			ok &= same("last", want.last, got.last);
			if (!ok) begin
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [KIND_W-1:0] kind = '0;
	logic [BYTE_W-1:0] data_byte = '0;
	logic              tx_ready = 1'b0;
	logic              empty;
	logic              pop = 1'b0;
	logic              tx_valid;
	logic [BYTE_W-1:0] tx_byte;
	logic              accepted;
	logic [FREE_W-1:0] free_space;
	logic              empty_res;
	logic              last;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data = '0;

	ring_scoreboard sb = new();

	int  cycles = 0;
	int  run_left = 4;
	bit  gaps_on = 1'b1;
	int  hold_requests = 0;
	int  holds_served = 0;

	byte_ring_fifo_burst_drain i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.data_byte  (data_byte),
		.tx_ready   (tx_ready),
		.empty      (empty),
		.pop        (pop),
		.tx_valid   (tx_valid),
		.tx_byte    (tx_byte),
		.accepted   (accepted),
		.free_space (free_space),
		.empty_res  (empty_res),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("byte_ring_fifo_burst_drain: mismatch");
			$finish;
		end
	end

	// Watch every handshake in one place so updates keep a fixed order
	always @(posedge clk) begin : monitor
		res_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				sb.set_burst(cfg_data);
			end
			if (push && full === 1'b0) begin
				sb.note_item(kind, data_byte, tx_ready);
			end
			if (pop && empty === 1'b0) begin
				got.tx_valid   = tx_valid;
				got.tx_byte    = tx_byte;
				got.accepted   = accepted;
				got.free_space = free_space;
				got.empty_res  = empty_res;
				got.last       = last;
				sb.check_result(got);
			end
		end
	end

	// Receiver: stall on a pattern that changes every so often, or hold off on request
	always @(posedge clk) begin : receiver
		int hold_left;
		int mode_left;
		int stall_mode;
		int rx_cycle;
		bit want;
		if (hold_left > 0) begin
			hold_left--;
		end else if (hold_requests != holds_served) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		if (mode_left <= 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 80);
		end
		mode_left--;
		case (stall_mode)
			0: begin
				want = 1'b1;
			end
			1: begin
				want = $urandom_range(0, 99) >= 30;
			end
			2: begin
				want = (rx_cycle % 7) >= 3;
			end
			default: begin
				want = $urandom_range(0, 99) >= 80;
			end
		endcase
		rx_cycle++;
		pop <= (hold_left == 0) && want;
	end

	// Offer one item and hold it until taken; close runs with random gaps
	task automatic offer_item(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] d,
		input logic r);
		push <= 1'b1;
		kind <= k;
		data_byte <= d;
		tx_ready <= r;
		do @(posedge clk); while (full !== 1'b0);
		if (gaps_on) begin
			if (run_left > 0) begin
				run_left--;
			end
			if (run_left == 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 8);
			end
		end
	endtask

	// Drop push and wait until every expected result is back
	task automatic wait_drained();
		push <= 1'b0;
		// let the monitor note the last item before counting what is due
		@(posedge clk);
		while (sb.due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_burst_size(input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] settings [5];
		logic [KIND_W-1:0] k;
		int pick;
		int enq_pct;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sends on an empty ring, then the unused kind
		offer_item(KIND_BURST, 8'h00, 1'b0);
		offer_item(KIND_SINGLE, 8'hFF, 1'b1);
		offer_item(KIND_SINGLE, 8'h00, 1'b0);
		offer_item(KIND_UNUSED, 8'h55, 1'b1);

		// Load extreme byte patterns
		offer_item(KIND_ENQ, 8'h00, 1'b0);
		offer_item(KIND_ENQ, 8'hFF, 1'b1);
		offer_item(KIND_ENQ, 8'hA5, 1'b0);
		offer_item(KIND_ENQ, 8'h5A, 1'b1);
		offer_item(KIND_ENQ, 8'h3C, 1'b0);
		offer_item(KIND_ENQ, 8'hC3, 1'b1);

		// Burst at the reset limit, busy transmitter, ready transmitter, unused kind
		offer_item(KIND_BURST, 8'hFF, 1'b1);
		offer_item(KIND_SINGLE, 8'h00, 1'b0);
		offer_item(KIND_SINGLE, 8'h00, 1'b1);
		offer_item(KIND_UNUSED, 8'hAA, 1'b0);

		// Zero limit saturates up to one
		wait_drained();
		write_burst_size(CFG_W'(0));
		offer_item(KIND_BURST, 8'h00, 1'b0);

		// Oversized limit saturates to the maximum; the burst ends when the ring empties
		wait_drained();
		write_burst_size(CFG_W'(127));
		offer_item(KIND_BURST, 8'h00, 1'b0);
		offer_item(KIND_BURST, 8'h00, 1'b0);

		// Enqueue back to back while the receiver holds off, so the block stalls its input
		wait_drained();
		write_burst_size(BURST_MAX);
		gaps_on = 1'b0;
		hold_requests++;
		for (int i = 0; i < FILL_ITEMS; i++) begin
			offer_item(KIND_ENQ, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
		gaps_on = 1'b1;
		run_left = 3;

		// Drain one burst at the full limit, one that empties the ring, then empty sends
		for (int i = 0; i < 5; i++) begin
			offer_item(KIND_BURST, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end

		// Random traffic under several burst limits
		settings[0] = CFG_W'(127);
		settings[1] = CFG_W'($urandom_range(2, 63));
		settings[2] = CFG_W'(0);
		settings[3] = CFG_W'($urandom_range(65, 126));
		settings[4] = CFG_W'($urandom_range(1, 8));
		for (int s = 0; s < 5; s++) begin
			wait_drained();
			write_burst_size(settings[s]);
			enq_pct = $urandom_range(35, 70);
			for (int i = 0; i < RANDOM_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < enq_pct) begin
					k = KIND_ENQ;
				end else if (pick < enq_pct + (94 - enq_pct) / 2) begin
					k = KIND_BURST;
				end else if (pick < 94) begin
					k = KIND_SINGLE;
				end else begin
					k = KIND_UNUSED;
				end
				offer_item(k, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.due.size() != 0) begin
			$display("%0t: %0d expected results never came", $time, sb.due.size());
			sb.errors++;
		end
		$display("Covered %0d items and %0d results: %0d bytes sent, %0d enqueues refused.",
			sb.items, sb.results, sb.bytes_sent, sb.dropped);
		$display("Burst limits from zero to 127 were written, with one long receiver hold-off.");
		if (sb.errors == 0) begin
			$display("byte_ring_fifo_burst_drain: match");
		end else begin
			$display("byte_ring_fifo_burst_drain: mismatch");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/brfb_pkg.sv
src/brfb_queue.sv
src/brfb_front.sv
src/brfb_back.sv
src/byte_ring_fifo_burst_drain.sv
tb/byte_ring_fifo_burst_drain_tb.sv
